### src/tcc_pkg.sv
// Shared types and constants for the text console cursor control block.
// Used by tcc_cursor_next, tcc_cmd_calc and text_console_cursor_control.
package tcc_pkg;

    localparam logic [7:0] CODE_BACKSPACE = 8'h08;
    localparam logic [7:0] CODE_RETURN    = 8'h0D;
    localparam logic [7:0] CODE_PRINT_MIN = 8'h20;
    localparam logic [7:0] CODE_SPACE     = 8'h20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR   = 3'd7;

    localparam logic [4:0]  RST_GLYPH_WIDTH  = 5'd11;
    localparam logic [5:0]  RST_GLYPH_HEIGHT = 6'd18;
    localparam logic [7:0]  RST_COLUMNS      = 8'd29;
    localparam logic [7:0]  RST_ROWS         = 8'd13;
    localparam logic [15:0] RST_FORE_COLOR   = 16'hFFFF;
    localparam logic [15:0] RST_BACK_COLOR   = 16'h0000;

    typedef enum logic [1:0] {
        KIND_ERASE = 2'd0,
        KIND_GLYPH = 2'd1,
        KIND_BAR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
        logic [4:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [7:0]  columns;
        logic [7:0]  rows;
        logic [15:0] fore_color;
        logic [15:0] back_color;
    } cfg_t;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
    } pos_t;

    typedef struct packed {
        kind_t      step;
        logic       is_bs;
        logic       has_glyph;
        logic [7:0] char_code;
        pos_t       old_pos;
        pos_t       new_pos;
    } job_t;

    typedef struct packed {
        kind_t       kind;
        logic [12:0] pixel_x;
        logic [13:0] pixel_y;
        logic [7:0]  glyph_code;
        logic [15:0] draw_color;
        logic        last_of_run;
    } cmd_t;

endpackage

### src/text_console_cursor_control.sv
// Each character is held as a job and its commands are output registered.
// A job issues erase, glyph, bar (erase, bar for codes that draw no glyph),
// one per cycle while m_ready holds, set by the sequencer stepping the job.
// Reset (aresetn low, synchronous): cursor to 0/0, registers to defaults,
// no job pending and no command valid.
// Depends on tcc_pkg, tcc_cursor_next, tcc_cmd_calc.
module text_console_cursor_control (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_char_code,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_draw_kind,
    output logic [12:0]                   m_pixel_x,
    output logic [13:0]                   m_pixel_y,
    output logic [7:0]                    m_glyph_code,
    output logic [15:0]                   m_draw_color,
    output logic                          m_last_of_run
);

    tcc_pkg::cfg_t cfg_reg;
    tcc_pkg::pos_t pos_reg;
    tcc_pkg::pos_t pos_next;
    tcc_pkg::job_t job_reg;
    tcc_pkg::cmd_t cmd_next;
    tcc_pkg::cmd_t out_reg;
    logic          job_valid_reg;
    logic          m_valid_reg;
    logic          in_bs;
    logic          in_glyph;
    logic          s_xfer;
    logic          out_load;
    logic          job_done;

    assign out_load = job_valid_reg && (!m_valid_reg || m_ready);
    assign job_done = out_load && (job_reg.step == tcc_pkg::KIND_BAR);
    assign s_ready  = !job_valid_reg || job_done;
    assign s_xfer   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.glyph_width  <= tcc_pkg::RST_GLYPH_WIDTH;
            cfg_reg.glyph_height <= tcc_pkg::RST_GLYPH_HEIGHT;
            cfg_reg.columns      <= tcc_pkg::RST_COLUMNS;
            cfg_reg.rows         <= tcc_pkg::RST_ROWS;
            cfg_reg.fore_color   <= tcc_pkg::RST_FORE_COLOR;
            cfg_reg.back_color   <= tcc_pkg::RST_BACK_COLOR;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tcc_pkg::CFG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_wdata[9:0];
                tcc_pkg::CFG_ORIGIN_Y:     cfg_reg.origin_y     <= cfg_wdata[9:0];
                tcc_pkg::CFG_GLYPH_WIDTH:  cfg_reg.glyph_width  <= cfg_wdata[4:0];
                tcc_pkg::CFG_GLYPH_HEIGHT: cfg_reg.glyph_height <= cfg_wdata[5:0];
                tcc_pkg::CFG_COLUMNS:      cfg_reg.columns      <= cfg_wdata[7:0];
                tcc_pkg::CFG_ROWS:         cfg_reg.rows         <= cfg_wdata[7:0];
                tcc_pkg::CFG_FORE_COLOR:   cfg_reg.fore_color   <= cfg_wdata;
                tcc_pkg::CFG_BACK_COLOR:   cfg_reg.back_color   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tcc_cursor_next u_cursor_next (
        .char_code (s_char_code),
        .cur_pos   (pos_reg),
        .columns   (cfg_reg.columns),
        .rows      (cfg_reg.rows),
        .next_pos  (pos_next),
        .is_bs     (in_bs),
        .has_glyph (in_glyph)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            job_valid_reg <= 1'b0;
            job_reg.step  <= tcc_pkg::KIND_ERASE;
        end else if (s_xfer) begin
            pos_reg           <= pos_next;
            job_valid_reg     <= 1'b1;
            job_reg.step      <= tcc_pkg::KIND_ERASE;
            job_reg.is_bs     <= in_bs;
            job_reg.has_glyph <= in_glyph;
            job_reg.char_code <= s_char_code;
            job_reg.old_pos   <= pos_reg;
            job_reg.new_pos   <= pos_next;
        end else if (job_done) begin
            job_valid_reg <= 1'b0;
        end else if (out_load) begin
            job_reg.step <= ((job_reg.step == tcc_pkg::KIND_ERASE) && job_reg.has_glyph)
                          ? tcc_pkg::KIND_GLYPH : tcc_pkg::KIND_BAR;
        end
    end

    tcc_cmd_calc u_cmd_calc (
        .job (job_reg),
        .cfg (cfg_reg),
        .cmd (cmd_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= cmd_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_draw_kind   = out_reg.kind;
    assign m_pixel_x     = out_reg.pixel_x;
    assign m_pixel_y     = out_reg.pixel_y;
    assign m_glyph_code  = out_reg.glyph_code;
    assign m_draw_color  = out_reg.draw_color;
    assign m_last_of_run = out_reg.last_of_run;

    a_new_job_starts_with_erase: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> job_valid_reg && (job_reg.step == tcc_pkg::KIND_ERASE))
        else $error("new job does not start with erase step");

    a_last_on_bar_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_of_run == (m_draw_kind == tcc_pkg::KIND_BAR)))
        else $error("last_of_run not aligned with bar command");

    a_erase_not_repeated: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (job_reg.step == tcc_pkg::KIND_ERASE)) |=>
        (job_reg.step != tcc_pkg::KIND_ERASE))
        else $error("erase command followed by another erase");

    a_no_take_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && !job_done) |-> !s_ready)
        else $error("character taken while a job is still pending");

endmodule

### src/tcc_cursor_next.sv
// Next cursor position for one character code.
// Depends on tcc_pkg.
module tcc_cursor_next (
    input  logic [7:0]    char_code,
    input  tcc_pkg::pos_t cur_pos,
    input  logic [7:0]    columns,
    input  logic [7:0]    rows,
    output tcc_pkg::pos_t next_pos,
    output logic          is_bs,
    output logic          has_glyph
);

    logic       is_ret;
    logic       is_print;
    logic [7:0] col_inc;
    logic [7:0] row_inc;
    logic [7:0] prt_row;

    assign is_bs     = (char_code == tcc_pkg::CODE_BACKSPACE);
    assign is_ret    = (char_code == tcc_pkg::CODE_RETURN);
    assign is_print  = (char_code >= tcc_pkg::CODE_PRINT_MIN);
    assign has_glyph = is_bs || is_print;

    assign col_inc = cur_pos.col + 8'd1;
    assign row_inc = cur_pos.row + 8'd1;

    always_comb begin
        next_pos = cur_pos;
        prt_row  = cur_pos.row;
        if (is_bs) begin
            if (cur_pos.col == 8'd0) begin
                next_pos.col = columns - 8'd2;
                next_pos.row = (cur_pos.row != 8'd0) ? cur_pos.row - 8'd1 : rows - 8'd1;
            end else begin
                next_pos.col = cur_pos.col - 8'd1;
            end
        end else if (is_ret) begin
            next_pos.col = 8'd0;
            next_pos.row = (({1'b0, cur_pos.row} + 9'd1) == {1'b0, rows}) ? 8'd0 : row_inc;
        end else if (is_print) begin
            // wrap one cell early: compare column+1 after the step
            if (({1'b0, col_inc} + 9'd1) == {1'b0, columns}) begin
                next_pos.col = 8'd0;
                prt_row      = row_inc;
            end else begin
                next_pos.col = col_inc;
            end
            next_pos.row = (prt_row == rows) ? 8'd0 : prt_row;
        end
    end

endmodule

### src/tcc_cmd_calc.sv
// Builds one draw command (kind, pixel place, code, color) for the current step.
// Depends on tcc_pkg.
module tcc_cmd_calc (
    input  tcc_pkg::job_t job,
    input  tcc_pkg::cfg_t cfg,
    output tcc_pkg::cmd_t cmd
);

    logic       use_old;
    logic [7:0] col;
    logic [7:0] row;
    logic [12:0] prod_x;
    logic [13:0] prod_y;

    assign use_old = (job.step == tcc_pkg::KIND_ERASE)
                  || ((job.step == tcc_pkg::KIND_GLYPH) && !job.is_bs);
    assign col = use_old ? job.old_pos.col : job.new_pos.col;
    assign row = use_old ? job.old_pos.row : job.new_pos.row;

    assign prod_x = 13'(col * cfg.glyph_width);
    assign prod_y = 14'(row * cfg.glyph_height);

    always_comb begin
        cmd.kind        = job.step;
        cmd.last_of_run = (job.step == tcc_pkg::KIND_BAR);
        case (job.step)
            tcc_pkg::KIND_GLYPH: begin
                cmd.pixel_x    = prod_x + 13'(cfg.origin_x);
                cmd.pixel_y    = prod_y + 14'(cfg.origin_y);
                cmd.glyph_code = job.is_bs ? tcc_pkg::CODE_SPACE : job.char_code;
                cmd.draw_color = cfg.fore_color;
            end
            tcc_pkg::KIND_ERASE: begin
                cmd.pixel_x    = prod_x;
                cmd.pixel_y    = prod_y + 14'(cfg.glyph_height);
                cmd.glyph_code = 8'd0;
                cmd.draw_color = cfg.back_color;
            end
            default: begin
                cmd.pixel_x    = prod_x;
                cmd.pixel_y    = prod_y + 14'(cfg.glyph_height);
                cmd.glyph_code = 8'd0;
                cmd.draw_color = cfg.fore_color;
            end
        endcase
    end

endmodule

### verif/text_console_cursor_control_checker.sv
// Checker for text_console_cursor_control: mirrors register writes and the cursor,
// predicts the draw commands of every character transfer and compares them in order.
// Depends on tcc_pkg.
`timescale 1ns / 1ps
module text_console_cursor_control_checker
    import tcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_char_code,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [1:0]            m_draw_kind,
    input  logic [12:0]           m_pixel_x,
    input  logic [13:0]           m_pixel_y,
    input  logic [7:0]            m_glyph_code,
    input  logic [15:0]           m_draw_color,
    input  logic                  m_last_of_run,
    output int                    fail_count,
    output int                    pending
);

    cfg_t regs;
    pos_t cursor;
    cmd_t expected_cmds[$];
    cmd_t exp_cmd;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic [12:0] bar_x();
        return 13'(32'(cursor.col) * 32'(regs.glyph_width));
    endfunction

    function automatic logic [13:0] bar_y();
        return 14'(32'(cursor.row) * 32'(regs.glyph_height) + 32'(regs.glyph_height));
    endfunction

    function automatic logic [12:0] cell_x();
        return 13'(32'(regs.origin_x) + 32'(cursor.col) * 32'(regs.glyph_width));
    endfunction

    function automatic logic [13:0] cell_y();
        return 14'(32'(regs.origin_y) + 32'(cursor.row) * 32'(regs.glyph_height));
    endfunction

    task automatic push_cmd(input kind_t kind, input logic [12:0] x, input logic [13:0] y,
                            input logic [7:0] code, input logic [15:0] color,
                            input logic last);
        cmd_t c;
        c.kind = kind;
        c.pixel_x = x;
        c.pixel_y = y;
        c.glyph_code = code;
        c.draw_color = color;
        c.last_of_run = last;
        expected_cmds.push_back(c);
    endtask

    task automatic predict_commands(input logic [7:0] ch);
        push_cmd(KIND_ERASE, bar_x(), bar_y(), 8'h00, regs.back_color, 1'b0);
        if (ch == CODE_BACKSPACE) begin
            if (cursor.col == 8'd0 && cursor.row != 8'd0) begin
                cursor.row = cursor.row - 8'd1;
                cursor.col = regs.columns - 8'd2;
            end else if (cursor.col == 8'd0) begin
                cursor.col = regs.columns - 8'd2;
                cursor.row = regs.rows - 8'd1;
            end else begin
                cursor.col = cursor.col - 8'd1;
            end
            push_cmd(KIND_GLYPH, cell_x(), cell_y(), CODE_SPACE, regs.fore_color, 1'b0);
        end else if (ch == CODE_RETURN) begin
            cursor.col = 8'd0;
            if ({1'b0, cursor.row} + 9'd1 == {1'b0, regs.rows}) begin
                cursor.row = 8'd0;
            end else begin
                cursor.row = cursor.row + 8'd1;
            end
        end else if (ch >= CODE_PRINT_MIN) begin
            push_cmd(KIND_GLYPH, cell_x(), cell_y(), ch, regs.fore_color, 1'b0);
            cursor.col = cursor.col + 8'd1;
            // wraps one cell early, at columns-1
            if ({1'b0, cursor.col} + 9'd1 == {1'b0, regs.columns}) begin
                cursor.col = 8'd0;
                cursor.row = cursor.row + 8'd1;
            end
            if (cursor.row == regs.rows) begin
                cursor.row = 8'd0;
            end
        end
        push_cmd(KIND_BAR, bar_x(), bar_y(), 8'h00, regs.fore_color, 1'b1);
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%t mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.origin_x = '0;
            regs.origin_y = '0;
            regs.glyph_width = RST_GLYPH_WIDTH;
            regs.glyph_height = RST_GLYPH_HEIGHT;
            regs.columns = RST_COLUMNS;
            regs.rows = RST_ROWS;
            regs.fore_color = RST_FORE_COLOR;
            regs.back_color = RST_BACK_COLOR;
            cursor = '0;
            expected_cmds.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ORIGIN_X:     regs.origin_x = cfg_wdata[9:0];
                    CFG_ORIGIN_Y:     regs.origin_y = cfg_wdata[9:0];
                    CFG_GLYPH_WIDTH:  regs.glyph_width = cfg_wdata[4:0];
                    CFG_GLYPH_HEIGHT: regs.glyph_height = cfg_wdata[5:0];
                    CFG_COLUMNS:      regs.columns = cfg_wdata[7:0];
                    CFG_ROWS:         regs.rows = cfg_wdata[7:0];
                    CFG_FORE_COLOR:   regs.fore_color = cfg_wdata;
                    CFG_BACK_COLOR:   regs.back_color = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_commands(s_char_code);
            end
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected transfer kind=%0d x=%0d y=%0d code=%02h color=%04h last=%0d",
                        m_draw_kind, m_pixel_x, m_pixel_y, m_glyph_code, m_draw_color,
                        m_last_of_run));
                end else begin
                    exp_cmd = expected_cmds.pop_front();
                    if (m_draw_kind !== exp_cmd.kind || m_pixel_x !== exp_cmd.pixel_x ||
                        m_pixel_y !== exp_cmd.pixel_y || m_glyph_code !== exp_cmd.glyph_code ||
                        m_draw_color !== exp_cmd.draw_color ||
                        m_last_of_run !== exp_cmd.last_of_run) begin
                        report_mismatch($sformatf(
                            {"exp kind=%0d x=%0d y=%0d code=%02h color=%04h last=%0d / ",
                             "got kind=%0d x=%0d y=%0d code=%02h color=%04h last=%0d"},
                            exp_cmd.kind, exp_cmd.pixel_x, exp_cmd.pixel_y,
                            exp_cmd.glyph_code, exp_cmd.draw_color, exp_cmd.last_of_run,
                            m_draw_kind, m_pixel_x, m_pixel_y, m_glyph_code, m_draw_color,
                            m_last_of_run));
                    end
                end
            end
        end
        pending = expected_cmds.size();
    end

endmodule

### verif/text_console_cursor_control_tb.sv
// Testbench top for text_console_cursor_control: clock, reset, register writes,
// character stimulus and draw-command backpressure; checking is done in the checker.
// Depends on tcc_pkg, text_console_cursor_control and text_console_cursor_control_checker.
`timescale 1ns / 1ps
module text_console_cursor_control_tb;
    import tcc_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_char_code = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_draw_kind;
    logic [12:0]           m_pixel_x;
    logic [13:0]           m_pixel_y;
    logic [7:0]            m_glyph_code;
    logic [15:0]           m_draw_color;
    logic                  m_last_of_run;
    int                    fail_count;
    int                    pending;
    bit                    quiet = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_console_cursor_control i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_draw_kind   (m_draw_kind),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_glyph_code  (m_glyph_code),
        .m_draw_color  (m_draw_color),
        .m_last_of_run (m_last_of_run)
    );

    text_console_cursor_control_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_draw_kind   (m_draw_kind),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_glyph_code  (m_glyph_code),
        .m_draw_color  (m_draw_color),
        .m_last_of_run (m_last_of_run),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // draw command sink with random stalls
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= ch;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_console(input logic [9:0] ox, input logic [9:0] oy,
                               input logic [4:0] gw, input logic [5:0] gh,
                               input logic [7:0] cols, input logic [7:0] nrows,
                               input logic [15:0] fg, input logic [15:0] bg);
        wait_drained();
        repeat (3) @(posedge aclk);
        write_reg(CFG_ORIGIN_X, 16'(ox));
        write_reg(CFG_ORIGIN_Y, 16'(oy));
        write_reg(CFG_GLYPH_WIDTH, 16'(gw));
        write_reg(CFG_GLYPH_HEIGHT, 16'(gh));
        write_reg(CFG_COLUMNS, 16'(cols));
        write_reg(CFG_ROWS, 16'(nrows));
        write_reg(CFG_FORE_COLOR, fg);
        write_reg(CFG_BACK_COLOR, bg);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 8'($urandom_range(32, 255));
        end else if (r < 70) begin
            return CODE_BACKSPACE;
        end else if (r < 85) begin
            return CODE_RETURN;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [7:0] at_reset[$];
        logic [7:0] tight_grid[$];
        logic [7:0] cols;
        logic [7:0] nrows;

        at_reset = '{CODE_RETURN, CODE_BACKSPACE, CODE_BACKSPACE, CODE_RETURN, CODE_RETURN,
                     8'h41, 8'hFF, CODE_PRINT_MIN, 8'h7F, 8'h00, 8'h1F, 8'h09, 8'h80,
                     8'hAA, 8'h55, CODE_BACKSPACE};
        tight_grid = '{CODE_RETURN, 8'h41, 8'h42, CODE_BACKSPACE, CODE_BACKSPACE,
                       CODE_RETURN, 8'hFF, CODE_PRINT_MIN};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (at_reset[i]) send_char(at_reset[i]);
        set_console(10'd1023, 10'd1023, 5'd16, 6'd32, 8'd2, 8'd1, 16'hFFFF, 16'hFFFF);
        foreach (tight_grid[i]) send_char(tight_grid[i]);

        for (int p = 0; p < 8; p++) begin
            if (p == 0) begin
                set_console(10'd1023, 10'd1023, 5'd16, 6'd32, 8'd255, 8'd255,
                            16'hFFFF, 16'hFFFF);
            end else if (p == 1) begin
                set_console(10'd0, 10'd0, 5'd1, 6'd1, 8'd2, 8'd1, 16'h0000, 16'h0000);
            end else begin
                cols = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(2, 12))
                                                   : 8'($urandom_range(2, 255));
                nrows = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 6))
                                                    : 8'($urandom_range(1, 255));
                set_console(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                            5'($urandom_range(1, 16)), 6'($urandom_range(1, 32)),
                            cols, nrows, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 65535)));
            end
            quiet = (p % 3 == 2);
            for (int n = 0; n < 56; n++) begin
                if (n == 28) begin
                    wait_drained();
                end
                send_char(pick_char());
            end
        end

        quiet = 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
src/tcc_pkg.sv
src/tcc_cursor_next.sv
src/tcc_cmd_calc.sv
src/text_console_cursor_control.sv
verif/text_console_cursor_control_checker.sv
verif/text_console_cursor_control_tb.sv
